### sv/jsu_pkg.sv
package jsu_pkg;

    // commands on the input tuser
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_EOT   = 2'd2;

    // result kinds on the output tuser
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_CLOSED  = 3'd1;
    localparam logic [2:0] KIND_UNTERM  = 3'd2;
    localparam logic [2:0] KIND_BADESC  = 3'd3;
    localparam logic [2:0] KIND_BADHEX  = 3'd4;
    localparam logic [2:0] KIND_BADSUR  = 3'd5;
    localparam logic [2:0] KIND_CTRL    = 3'd6;

    // decoder modes
    localparam logic [2:0] MODE_DONE     = 3'd0;
    localparam logic [2:0] MODE_TEXT     = 3'd1;
    localparam logic [2:0] MODE_ESC      = 3'd2;
    localparam logic [2:0] MODE_HEX      = 3'd3;
    localparam logic [2:0] MODE_WANT_BSL = 3'd4;
    localparam logic [2:0] MODE_WANT_U   = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HIGH_SUR_MIN = 16'hd800;
    localparam logic [15:0] HIGH_SUR_MAX = 16'hdbff;
    localparam logic [15:0] LOW_SUR_MIN  = 16'hdc00;
    localparam logic [15:0] LOW_SUR_MAX  = 16'hdfff;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    // one queued job: up to four result bytes, or a single status result
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [2:0]      kind;
    } job_t;

    function automatic job_t byte_job(input logic [7:0] b);
        job_t j;
        j = '0;
        j.bytes[0] = b;
        j.kind = KIND_BYTE;
        return j;
    endfunction

    function automatic job_t status_job(input logic [2:0] k);
        job_t j;
        j = '0;
        j.kind = k;
        return j;
    endfunction

    function automatic job_t utf8_job(input logic [20:0] cp);
        job_t j;
        j = '0;
        j.kind = KIND_BYTE;
        if (cp <= 21'h7f)
        begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end
        else if (cp <= 21'h7ff)
        begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end
        else if (cp <= 21'hffff)
        begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end
        else
        begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    // returns {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

endpackage

### sv/jsu_front.sv
module jsu_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         in_byte,
    output logic               push,
    output jsu_pkg::job_t      push_job,
    input  logic               queue_full
);
    import jsu_pkg::*;

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [9:0]  high_bits_reg, high_bits_next;
    logic        second_reg, second_next;

    logic        accept;
    logic [4:0]  nib;
    logic [15:0] unit;
    logic [20:0] pair_cp;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign nib      = hex_nibble(in_byte);
    assign unit     = {hex_reg[11:0], nib[3:0]};
    assign pair_cp  = SUPPLEMENTARY_BASE + 21'({high_bits_reg, unit[9:0]});

    always_comb
    begin
        mode_next      = mode_reg;
        hex_next       = hex_reg;
        hex_cnt_next   = hex_cnt_reg;
        high_bits_next = high_bits_reg;
        second_next    = second_reg;
        push           = 1'b0;
        push_job       = status_job(KIND_BYTE);

        if (accept)
        begin
            if (cmd == CMD_START)
            begin
                mode_next      = MODE_TEXT;
                hex_next       = '0;
                hex_cnt_next   = '0;
                high_bits_next = '0;
                second_next    = 1'b0;
            end
            else if (cmd == CMD_EOT && mode_reg != MODE_DONE)
            begin
                second_next = 1'b0;
                mode_next   = MODE_DONE;
                push        = 1'b1;
                push_job    = status_job(KIND_UNTERM);
            end
            else if (cmd == CMD_DATA)
            begin
                unique case (mode_reg)
                    MODE_TEXT:
                    begin
                        if (in_byte == CH_QUOTE)
                        begin
                            mode_next = MODE_DONE;
                            push      = 1'b1;
                            push_job  = status_job(KIND_CLOSED);
                        end
                        else if (in_byte == CH_BSL)
                            mode_next = MODE_ESC;
                        else if (in_byte < CH_SPACE)
                        begin
                            mode_next = MODE_DONE;
                            push      = 1'b1;
                            push_job  = status_job(KIND_CTRL);
                        end
                        else
                        begin
                            push     = 1'b1;
                            push_job = byte_job(in_byte);
                        end
                    end
                    MODE_ESC:
                    begin
                        mode_next = MODE_TEXT;
                        push      = 1'b1;
                        unique case (in_byte) inside
                            CH_QUOTE, CH_BSL, CH_SLASH: push_job = byte_job(in_byte);
                            CH_B: push_job = byte_job(8'h08);
                            CH_F: push_job = byte_job(8'h0c);
                            CH_N: push_job = byte_job(8'h0a);
                            CH_R: push_job = byte_job(8'h0d);
                            CH_T: push_job = byte_job(8'h09);
                            CH_U:
                            begin
                                push         = 1'b0;
                                mode_next    = MODE_HEX;
                                hex_next     = '0;
                                hex_cnt_next = '0;
                                second_next  = 1'b0;
                            end
                            default:
                            begin
                                mode_next = MODE_DONE;
                                push_job  = status_job(KIND_BADESC);
                            end
                        endcase
                    end
                    MODE_HEX:
                    begin
                        if (!nib[4])
                        begin
                            second_next = 1'b0;
                            mode_next   = MODE_DONE;
                            push        = 1'b1;
                            push_job    = status_job(KIND_BADHEX);
                        end
                        else
                        begin
                            hex_next = unit;
                            if (hex_cnt_reg != 2'd3)
                                hex_cnt_next = 2'(hex_cnt_reg + 2'd1);
                            else
                            begin
                                hex_cnt_next = '0;
                                if (second_reg)
                                begin
                                    second_next = 1'b0;
                                    push        = 1'b1;
                                    if (unit < LOW_SUR_MIN || unit > LOW_SUR_MAX)
                                    begin
                                        mode_next = MODE_DONE;
                                        push_job  = status_job(KIND_BADSUR);
                                    end
                                    else
                                    begin
                                        mode_next = MODE_TEXT;
                                        push_job  = utf8_job(pair_cp);
                                    end
                                end
                                else if (unit >= HIGH_SUR_MIN && unit <= HIGH_SUR_MAX)
                                begin
                                    high_bits_next = unit[9:0];
                                    mode_next      = MODE_WANT_BSL;
                                end
                                else if (unit >= LOW_SUR_MIN && unit <= LOW_SUR_MAX)
                                begin
                                    mode_next = MODE_DONE;
                                    push      = 1'b1;
                                    push_job  = status_job(KIND_BADSUR);
                                end
                                else
                                begin
                                    mode_next = MODE_TEXT;
                                    push      = 1'b1;
                                    push_job  = utf8_job({5'd0, unit});
                                end
                            end
                        end
                    end
                    MODE_WANT_BSL:
                    begin
                        if (in_byte != CH_BSL)
                        begin
                            mode_next = MODE_DONE;
                            push      = 1'b1;
                            push_job  = status_job(KIND_BADSUR);
                        end
                        else
                            mode_next = MODE_WANT_U;
                    end
                    MODE_WANT_U:
                    begin
                        if (in_byte != CH_U)
                        begin
                            mode_next = MODE_DONE;
                            push      = 1'b1;
                            push_job  = status_job(KIND_BADSUR);
                        end
                        else
                        begin
                            mode_next    = MODE_HEX;
                            hex_next     = '0;
                            hex_cnt_next = '0;
                            second_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        // finished: data is dropped until the next start
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DONE;
            hex_reg       <= '0;
            hex_cnt_reg   <= '0;
            high_bits_reg <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            hex_reg       <= hex_next;
            hex_cnt_reg   <= hex_cnt_next;
            high_bits_reg <= high_bits_next;
            second_reg    <= second_next;
        end
    end

endmodule

### sv/jsu_queue.sv
module jsu_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::job_t push_job,
    output logic          full,
    output logic          head_valid,
    output jsu_pkg::job_t head_job,
    input  logic          pop
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    job_t          entries [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : AW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : AW'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CW'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_job;
    end

endmodule

### sv/jsu_back.sv
module jsu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  jsu_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [2:0]    kind,
    output logic          last
);
    import jsu_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [2:0] kind_reg;
    logic       last_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load, final_byte;

    // output register is free when empty or being drained this cycle
    assign load       = head_valid && (!valid_reg || out_ready);
    assign final_byte = (idx_reg == head_job.last_idx);
    assign pop        = load && final_byte;
    assign idx_next   = pop ? 2'd0 : (load ? 2'(idx_reg + 2'd1) : idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head_job.bytes[idx_reg];
            kind_reg <= head_job.kind;
            last_reg <= final_byte;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;

endmodule

### sv/json_string_unescape.sv
// path: the first result an input causes is registered in a job queue entry, then in the
//   output register; further bytes of a multi-byte result follow one per cycle unless stalled
// flow: one input per cycle while each input yields at most one result and the output is not
//   stalled; a \u escape that expands to n utf-8 bytes holds the output serializer until all n
//   are out, and the job queue (QUEUE_DEPTH entries) lets input keep flowing meanwhile
// reset: rst_n is asynchronous, active low; decoder returns to finished, queue and output empty
module json_string_unescape
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [2:0] kind
    output logic       m_axis_tlast
);
    import jsu_pkg::*;

    logic push, full, head_valid, pop;
    job_t push_job, head_job;

    jsu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .cmd        (s_axis_tuser),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_job   (push_job),
        .queue_full (full)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .kind       (m_axis_tuser),
        .last       (m_axis_tlast)
    );

endmodule

### sv/jsu_checker.sv
module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import jsu_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // status results stand alone
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tlast)
        else $error("status result not marked last");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata == 8'h00)
        else $error("status result carries data");

    // a transferred byte that is not last is followed by a utf-8 continuation byte of the same run
    a_cont_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser == KIND_BYTE && m_axis_tdata[7:6] == 2'b10)
        else $error("multi-byte run broken");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
